// ----- src/tcws_pkg.sv -----
// Shared types and constants of the two-class weighted service scheduler.
package tcws_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 128;
	localparam int unsigned ARRIVAL_W       = 32;
	localparam int unsigned SERVICE_W       = 16;
	localparam int unsigned CLOCK_W         = 32;
	localparam int unsigned COUNT_W         = 16;
	localparam int unsigned SUM_W           = 48;
	localparam int unsigned BURST_W         = 4;
	localparam int unsigned JOB_W           = ARRIVAL_W + SERVICE_W;

	localparam logic [BURST_W-1:0] BURST_RESET = 4'd2;
	localparam logic [BURST_W-1:0] BURST_MAX   = 4'd15;

	typedef enum logic [1:0] {
		ACT_ENQ_PRI = 2'd0,
		ACT_ENQ_REG = 2'd1,
		ACT_STEP    = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		ST_QUEUED     = 3'd0,
		ST_DROPPED    = 3'd1,
		ST_SERVED_PRI = 3'd2,
		ST_SERVED_REG = 3'd3,
		ST_IDLE_TICK  = 3'd4,
		ST_EMPTY      = 3'd5
	} status_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} tcws_cmd_t;

endpackage

// ----- src/tcws_ram.sv -----
// Generic single-port-write, registered-read RAM.
module tcws_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/tcws_ctrl.sv -----
// Controller state machine: request capture and execute sequencing, result handshake.
module tcws_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output tcws_pkg::tcws_cmd_t cmd
);
	import tcws_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_stall    = (state_q != S_IDLE);
	assign cmd.capture = in_valid && (state_q == S_IDLE);
	assign cmd.execute = (state_q == S_EXEC) && (!out_valid_q || !out_stall);
	assign out_valid   = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.capture) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (cmd.execute) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.execute) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_exec_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.execute |-> in_stall)
		else $error("execute outside of busy state");

	a_result_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.execute |=> out_valid)
		else $error("result not presented after execute");

	a_capture_starts_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == S_EXEC))
		else $error("accepted request did not start execution");

endmodule

// ----- src/tcws_dp.sv -----
// Datapath: job queues, scheduling clock, burst counter, statistics and result register.
module tcws_dp #(
	parameter int unsigned QUEUE_DEPTH = tcws_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tcws_pkg::tcws_cmd_t               cmd,
	input  logic                              cfg_we,
	input  logic [tcws_pkg::BURST_W-1:0]      cfg_wdata,
	input  logic [1:0]                        action,
	input  logic [tcws_pkg::ARRIVAL_W-1:0]    arrival_tick,
	input  logic [tcws_pkg::SERVICE_W-1:0]    service_ticks,
	output logic [2:0]                        status,
	output logic [tcws_pkg::CLOCK_W-1:0]      start_time,
	output logic [tcws_pkg::SERVICE_W-1:0]    job_service_ticks,
	output logic [tcws_pkg::CLOCK_W-1:0]      job_wait,
	output logic [tcws_pkg::COUNT_W-1:0]      served_priority,
	output logic [tcws_pkg::COUNT_W-1:0]      served_regular,
	output logic [tcws_pkg::SUM_W-1:0]        wait_total_priority,
	output logic [tcws_pkg::SUM_W-1:0]        wait_total_regular
);
	import tcws_pkg::*;

	localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned TW = $clog2(2 * QUEUE_DEPTH);

	localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);
	localparam logic [AW-1:0] HEAD_LAST = AW'(QUEUE_DEPTH - 1);
	localparam logic [TW-1:0] TAIL_WRAP = TW'(QUEUE_DEPTH);

	logic [1:0]           action_q;
	logic [ARRIVAL_W-1:0] arrival_q;
	logic [SERVICE_W-1:0] service_q;
	logic [BURST_W-1:0]   burst_cfg_q;
	logic [BURST_W-1:0]   burst_q;
	logic [AW-1:0]        p_head_q, r_head_q;
	logic [CW-1:0]        p_count_q, r_count_q;
	logic [CLOCK_W-1:0]   clock_q;
	logic [COUNT_W-1:0]   p_served_q, r_served_q;
	logic [SUM_W-1:0]     p_sum_q, r_sum_q;
	logic [2:0]           status_q;
	logic [CLOCK_W-1:0]   start_q;
	logic [SERVICE_W-1:0] jsvc_q;
	logic [CLOCK_W-1:0]   jwait_q;

	logic [JOB_W-1:0] p_job, r_job;
	logic             is_enq, is_pri_enq, full;
	logic [TW-1:0]    tail_sum, tail_fix;
	logic [AW-1:0]    tail;
	logic             p_we, r_we;

	logic [ARRIVAL_W-1:0] p_arr, r_arr;
	logic [SERVICE_W-1:0] p_svc, r_svc;
	logic                 p_ne, r_ne, p_try, p_ok, r_ok;
	logic [CLOCK_W-1:0]   p_wait, r_wait, sel_wait;
	logic [SERVICE_W-1:0] sel_svc;
	logic [SUM_W:0]       p_sum_add, r_sum_add;
	logic [CLOCK_W:0]     clk_add;
	logic [CLOCK_W-1:0]   clk_next;
	logic [2:0]           status_d;

	assign is_enq     = (action_q == ACT_ENQ_PRI) || (action_q == ACT_ENQ_REG);
	assign is_pri_enq = (action_q == ACT_ENQ_PRI);
	assign full       = is_pri_enq ? (p_count_q == CNT_FULL) : (r_count_q == CNT_FULL);
	assign tail_sum   = is_pri_enq ? (TW'(p_head_q) + TW'(p_count_q))
	                               : (TW'(r_head_q) + TW'(r_count_q));
	assign tail_fix   = (tail_sum >= TAIL_WRAP) ? (tail_sum - TAIL_WRAP) : tail_sum;
	assign tail       = tail_fix[AW-1:0];
	assign p_we       = cmd.execute && is_enq && is_pri_enq && !full;
	assign r_we       = cmd.execute && is_enq && !is_pri_enq && !full;

	tcws_ram #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_pri_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (tail),
		.wdata ({arrival_q, service_q}),
		.raddr (p_head_q),
		.rdata (p_job)
	);

	tcws_ram #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_reg_ram (
		.clk   (clk),
		.we    (r_we),
		.waddr (tail),
		.wdata ({arrival_q, service_q}),
		.raddr (r_head_q),
		.rdata (r_job)
	);

	assign p_arr  = p_job[JOB_W-1:SERVICE_W];
	assign p_svc  = p_job[SERVICE_W-1:0];
	assign r_arr  = r_job[JOB_W-1:SERVICE_W];
	assign r_svc  = r_job[SERVICE_W-1:0];
	assign p_ne   = (p_count_q != '0);
	assign r_ne   = (r_count_q != '0);
	assign p_try  = p_ne && ((burst_q < burst_cfg_q) || !r_ne);
	assign p_ok   = p_try && (p_arr <= clock_q);
	assign r_ok   = !p_ok && r_ne && (r_arr <= clock_q);
	assign p_wait = clock_q - p_arr;
	assign r_wait = clock_q - r_arr;

	assign sel_wait  = p_ok ? p_wait : (r_ok ? r_wait : '0);
	assign sel_svc   = p_ok ? p_svc : (r_ok ? r_svc : '0);
	assign p_sum_add = {1'b0, p_sum_q} + (SUM_W + 1)'(p_wait);
	assign r_sum_add = {1'b0, r_sum_q} + (SUM_W + 1)'(r_wait);
	assign clk_add   = (p_ok || r_ok) ? ({1'b0, clock_q} + (CLOCK_W + 1)'(sel_svc))
	                                  : ({1'b0, clock_q} + (CLOCK_W + 1)'(1'b1));
	assign clk_next  = clk_add[CLOCK_W] ? '1 : clk_add[CLOCK_W-1:0];

	always_comb begin
		if (is_enq) begin
			status_d = full ? ST_DROPPED : ST_QUEUED;
		end else if (!p_ne && !r_ne) begin
			status_d = ST_EMPTY;
		end else if (p_ok) begin
			status_d = ST_SERVED_PRI;
		end else if (r_ok) begin
			status_d = ST_SERVED_REG;
		end else begin
			status_d = ST_IDLE_TICK;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q  <= action;
			arrival_q <= arrival_tick;
			service_q <= service_ticks;
		end
		if (cmd.execute) begin
			status_q <= status_d;
			start_q  <= clock_q;
			if (is_enq) begin
				jsvc_q  <= '0;
				jwait_q <= '0;
			end else begin
				jsvc_q  <= sel_svc;
				jwait_q <= sel_wait;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_cfg_q <= BURST_RESET;
			burst_q     <= '0;
			p_head_q    <= '0;
			r_head_q    <= '0;
			p_count_q   <= '0;
			r_count_q   <= '0;
			clock_q     <= '0;
			p_served_q  <= '0;
			r_served_q  <= '0;
			p_sum_q     <= '0;
			r_sum_q     <= '0;
		end else begin
			if (cfg_we) begin
				burst_cfg_q <= cfg_wdata;
			end
			if (p_we) begin
				p_count_q <= p_count_q + CW'(1);
			end
			if (r_we) begin
				r_count_q <= r_count_q + CW'(1);
			end
			if (cmd.execute && !is_enq && (p_ne || r_ne)) begin
				clock_q <= clk_next;
				if (p_ok) begin
					p_head_q   <= (p_head_q == HEAD_LAST) ? '0 : p_head_q + AW'(1);
					p_count_q  <= p_count_q - CW'(1);
					p_sum_q    <= p_sum_add[SUM_W] ? '1 : p_sum_add[SUM_W-1:0];
					p_served_q <= (p_served_q == '1) ? p_served_q : p_served_q + COUNT_W'(1);
					if (burst_q != BURST_MAX) begin
						burst_q <= burst_q + BURST_W'(1);
					end
				end else if (r_ok) begin
					r_head_q   <= (r_head_q == HEAD_LAST) ? '0 : r_head_q + AW'(1);
					r_count_q  <= r_count_q - CW'(1);
					r_sum_q    <= r_sum_add[SUM_W] ? '1 : r_sum_add[SUM_W-1:0];
					r_served_q <= (r_served_q == '1) ? r_served_q : r_served_q + COUNT_W'(1);
					burst_q    <= '0;
				end
			end
		end
	end

	assign status              = status_q;
	assign start_time          = start_q;
	assign job_service_ticks   = jsvc_q;
	assign job_wait            = jwait_q;
	assign served_priority     = p_served_q;
	assign served_regular      = r_served_q;
	assign wait_total_priority = p_sum_q;
	assign wait_total_regular  = r_sum_q;

	a_pri_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		p_count_q <= CNT_FULL)
		else $error("priority queue count beyond depth");

	a_reg_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		r_count_q <= CNT_FULL)
		else $error("regular queue count beyond depth");

	a_clock_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.execute |=> clock_q >= $past(clock_q))
		else $error("scheduling clock went backward");

	a_burst_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.execute && !is_enq && r_ok) |=> (burst_q == '0))
		else $error("burst count not cleared after regular service");

endmodule

// ----- src/two_class_weighted_service_scheduler.sv -----
// Top level of the two-class weighted service scheduler.
//
//   port group      | dir | handshake          | payload
//   request         | in  | in_valid/in_stall  | action, arrival_tick, service_ticks
//   result          | out | out_valid/out_stall| status .. wait_total_regular
//   configuration   | in  | cfg_we             | cfg_wdata (priority burst)
//
// Each request is captured, with the queue head read from RAM, and is then executed.
// Execute waits while a previous result is still stalled in the output register.
// Queue storage is uninitialized RAM; reset clears pointers, counts, clock and totals.
// The priority burst resets to two; write it only while no request is in flight.
module two_class_weighted_service_scheduler #(
	parameter int unsigned QUEUE_DEPTH = tcws_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        action,
	input  logic [tcws_pkg::ARRIVAL_W-1:0]    arrival_tick,
	input  logic [tcws_pkg::SERVICE_W-1:0]    service_ticks,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [2:0]                        status,
	output logic [tcws_pkg::CLOCK_W-1:0]      start_time,
	output logic [tcws_pkg::SERVICE_W-1:0]    job_service_ticks,
	output logic [tcws_pkg::CLOCK_W-1:0]      job_wait,
	output logic [tcws_pkg::COUNT_W-1:0]      served_priority,
	output logic [tcws_pkg::COUNT_W-1:0]      served_regular,
	output logic [tcws_pkg::SUM_W-1:0]        wait_total_priority,
	output logic [tcws_pkg::SUM_W-1:0]        wait_total_regular,
	input  logic                              cfg_we,
	input  logic [tcws_pkg::BURST_W-1:0]      cfg_wdata
);
	import tcws_pkg::*;

	tcws_cmd_t cmd;

	tcws_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	tcws_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.cfg_we              (cfg_we),
		.cfg_wdata           (cfg_wdata),
		.action              (action),
		.arrival_tick        (arrival_tick),
		.service_ticks       (service_ticks),
		.status              (status),
		.start_time          (start_time),
		.job_service_ticks   (job_service_ticks),
		.job_wait            (job_wait),
		.served_priority     (served_priority),
		.served_regular      (served_regular),
		.wait_total_priority (wait_total_priority),
		.wait_total_regular  (wait_total_regular)
	);

endmodule
